// File: rtl/upd_pkg.sv
`default_nettype none

package upd_pkg;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	// escape tracking
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// one queue entry: the 1 to 3 result beats caused by one input beat
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] data;
		logic            has;
		logic            last;
	} op_t;

	typedef struct packed {
		op_t        op;
		phase_t     next_phase;
		logic [7:0] next_held;
	} step_t;

	function automatic step_t decode_step(phase_t phase, logic [7:0] held,
		logic [7:0] b, logic last);
		step_t           s;
		logic [1:0]      n;
		logic [2:0][7:0] d;
		logic [3:0]      hi;
		logic [3:0]      lo;
		logic            lo_ok;
		logic            ok;
		logic [7:0]      val;
		phase_t          np;
		logic [7:0]      nh;
		s     = '0;
		n     = 2'd0;
		d     = '0;
		np    = PH_IDLE;
		nh    = held;
		hi    = held[3:0];
		lo    = 4'd0;
		lo_ok = 1'b0;
		ok    = 1'b0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			lo    = b[3:0];
			lo_ok = 1'b1;
		end else if (b >= CH_UP_A && b <= CH_UP_F) begin
			lo    = b[3:0] + 4'd9;
			lo_ok = 1'b1;
		end
		unique case (hi)
			4'd2:    ok = 1'b1;
			4'd3:    ok = (lo >= 4'd10);
			4'd4:    ok = (lo == 4'd0);
			4'd5:    ok = (lo >= 4'd11);
			4'd6:    ok = (lo == 4'd0);
			4'd7:    ok = (lo >= 4'd11) && (lo <= 4'd14);
			default: ok = 1'b0;
		endcase
		ok  = ok && lo_ok;
		val = {hi, lo};
		if (val == CH_SPACE) begin
			val = CH_PLUS;
		end
		unique case (phase)
			PH_PCT: begin
				nh = b;
				np = PH_DIGIT;
			end
			PH_DIGIT: begin
				nh = 8'd0;
				if (held < CH_TWO || held > CH_SEVEN) begin
					// whole triple dropped
				end else if (ok) begin
					d[n] = val;
					n    = n + 2'd1;
				end else begin
					d[n] = CH_PCT;
					n    = n + 2'd1;
					d[n] = held;
					n    = n + 2'd1;
					if (b == CH_SPACE) begin
						d[n] = CH_PLUS;
						n    = n + 2'd1;
					end else if (b == CH_PCT) begin
						np = PH_PCT;
					end else begin
						d[n] = b;
						n    = n + 2'd1;
					end
				end
			end
			default: begin
				if (b == CH_SPACE) begin
					d[n] = CH_PLUS;
					n    = n + 2'd1;
				end else if (b == CH_PCT) begin
					np = PH_PCT;
				end else begin
					d[n] = b;
					n    = n + 2'd1;
				end
			end
		endcase
		s.op.has = 1'b1;
		if (last) begin
			if (np == PH_PCT) begin
				d[n] = CH_PCT;
				n    = n + 2'd1;
			end else if (np == PH_DIGIT) begin
				d[n] = CH_PCT;
				n    = n + 2'd1;
				d[n] = nh;
				n    = n + 2'd1;
			end
			np = PH_IDLE;
			nh = 8'd0;
			if (n == 2'd0) begin
				s.op.has = 1'b0;
				n        = 2'd1;
			end
		end
		s.op.cnt     = n;
		s.op.data    = d;
		s.op.last    = last;
		s.next_phase = np;
		s.next_held  = nh;
		return s;
	endfunction

endpackage

`default_nettype wire

// File: rtl/upd_front.sv
`default_nettype none

module upd_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       q_full,
	output logic            q_push,
	output upd_pkg::op_t    q_op
);

	upd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      held_q, held_d;
	upd_pkg::step_t  step;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			held_q  <= 8'd0;
		end else begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	always_comb begin
		in_ready = !q_full;
		accept   = in_valid && in_ready;
		step     = upd_pkg::decode_step(phase_q, held_q, in_byte, in_last);
		phase_d  = phase_q;
		held_d   = held_q;
		if (accept) begin
			phase_d = step.next_phase;
			held_d  = step.next_held;
		end
		// beats that leave nothing to emit are not queued
		q_push = accept && (step.op.cnt != 2'd0);
		q_op   = step.op;
	end

endmodule

`default_nettype wire

// File: rtl/upd_queue.sv
`default_nettype none

module upd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire upd_pkg::op_t push_op,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output upd_pkg::op_t      head_op
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	upd_pkg::op_t  entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/upd_back.sv
`default_nettype none

module upd_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire upd_pkg::op_t head_op,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        out_byte,
	output logic              has_byte,
	output logic              out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       has_q;
	logic       last_q;
	logic       load;
	logic       final_beat;

	assign load       = head_valid && (!valid_q || out_ready);
	assign final_beat = (idx_q == head_op.cnt - 2'd1);
	assign pop        = load && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_beat ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_op.data[idx_q];
			has_q  <= head_op.has;
			last_q <= head_op.last && final_beat;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign has_byte  = has_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

// File: rtl/url_percent_decoder_unit.sv
// channel | valid    | ready     | payload
// input   | in_valid | in_ready  | in_byte[7:0], in_last
// output  | out_valid| out_ready | out_byte[7:0], has_byte, out_last
//
// one input beat is taken per cycle while the op queue has room
// each input beat yields 0 to 3 output beats, which pass through the op queue and
// the output register and leave it at one per cycle while out_ready is high
// a stalled output fills the QUEUE_DEPTH entry op queue, then in_ready drops
// arst_n clears the escape state, the queue and the output register
`default_nettype none

module url_percent_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            out_last
);

	// front to queue
	logic         q_full;
	logic         q_push;
	upd_pkg::op_t q_op;

	// queue to back
	logic         q_pop;
	logic         head_valid;
	upd_pkg::op_t head_op;

	// front: escape state machine, classifies each beat into a group of results
	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (q_op)
	);

	// short queue of result groups, decouples the two sides
	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	// back: walks each group one result beat at a time into the output register
	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.out_last   (out_last)
	);

endmodule

`default_nettype wire

// File: rtl/upd_checker.sv
`default_nettype none

module upd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       has_byte,
	input wire logic       out_last
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(has_byte)
			&& $stable(out_last))
		else $error("output beat changed while stalled");

	// an empty beat is only ever the end marker
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_last && (out_byte == 8'd0))
		else $error("empty beat that is not an end marker");

	// nothing is offered while reset is applied
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	// the input is ready right after reset
	a_ready_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> in_ready)
		else $error("input not ready right after reset");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.has_byte  (has_byte),
	.out_last  (out_last)
);

`default_nettype wire

// File: sim/query_decode_checker.sv
`timescale 1ns / 100ps

module query_decode_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_byte,
	input  wire logic       has_byte,
	input  wire logic       out_last,
	output int unsigned     mismatches,
	output int unsigned     pending,
	output int unsigned     beats_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} decoded_beat_t;

	decoded_beat_t   expected_q[$];
	upd_pkg::phase_t esc_phase;
	logic [7:0]      first_digit;

	// upper-case hex code check, val gets the decoded byte
	function automatic logic escape_decodes(input logic [7:0] d, input logic [7:0] c,
		output logic [7:0] val);
		logic [3:0] lo;
		logic       lo_ok;
		logic       ok;
		lo    = 4'd0;
		lo_ok = 1'b1;
		if (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_NINE) begin
			lo = c[3:0];
		end else if (c >= upd_pkg::CH_UP_A && c <= upd_pkg::CH_UP_F) begin
			lo = c[3:0] + 4'd9;
		end else begin
			lo_ok = 1'b0;
		end
		case (d[3:0])
			4'd2:    ok = 1'b1;
			4'd3:    ok = (lo >= 4'd10);
			4'd4:    ok = (lo == 4'd0);
			4'd5:    ok = (lo >= 4'd11);
			4'd6:    ok = (lo == 4'd0);
			4'd7:    ok = (lo >= 4'd11) && (lo <= 4'd14);
			default: ok = 1'b0;
		endcase
		val = {d[3:0], lo};
		if (val == upd_pkg::CH_SPACE) begin
			val = upd_pkg::CH_PLUS;
		end
		return ok && lo_ok;
	endfunction

	function automatic void add_result(input logic [7:0] b);
		expected_q.push_back({b, 1'b1, 1'b0});
	endfunction

	function automatic void plain_byte(input logic [7:0] b);
		if (b == upd_pkg::CH_SPACE) begin
			add_result(upd_pkg::CH_PLUS);
		end else if (b == upd_pkg::CH_PCT) begin
			esc_phase = upd_pkg::PH_PCT;
		end else begin
			add_result(b);
		end
	endfunction

	function automatic void predict_decode(input logic [7:0] b, input logic l);
		int unsigned base;
		logic [7:0]  d;
		logic [7:0]  val;
		base = expected_q.size();
		case (esc_phase)
			upd_pkg::PH_PCT: begin
				first_digit = b;
				esc_phase   = upd_pkg::PH_DIGIT;
			end
			upd_pkg::PH_DIGIT: begin
				d           = first_digit;
				esc_phase   = upd_pkg::PH_IDLE;
				first_digit = 8'h00;
				if (d < upd_pkg::CH_TWO || d > upd_pkg::CH_SEVEN) begin
					// bad first digit, all three bytes vanish
				end else if (escape_decodes(d, b, val)) begin
					add_result(val);
				end else begin
					add_result(upd_pkg::CH_PCT);
					add_result(d);
					plain_byte(b);
				end
			end
			default: begin
				esc_phase = upd_pkg::PH_IDLE;
				plain_byte(b);
			end
		endcase
		if (l) begin
			if (esc_phase == upd_pkg::PH_PCT) begin
				add_result(upd_pkg::CH_PCT);
			end else if (esc_phase == upd_pkg::PH_DIGIT) begin
				add_result(upd_pkg::CH_PCT);
				add_result(first_digit);
			end
			esc_phase   = upd_pkg::PH_IDLE;
			first_digit = 8'h00;
			if (expected_q.size() == base) begin
				expected_q.push_back({8'h00, 1'b0, 1'b0});
			end
			expected_q[expected_q.size() - 1].last = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_beat_t want;
		if (!arst_n) begin
			expected_q.delete();
			esc_phase     = upd_pkg::PH_IDLE;
			first_digit   = 8'h00;
			mismatches    = 0;
			beats_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected: out_byte=%h has_byte=%b out_last=%b",
						out_byte, has_byte, out_last);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, out_byte);
						mismatches++;
					end
					if (has_byte !== want.has) begin
						$error("has_byte: expected %b, got %b", want.has, has_byte);
						mismatches++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, out_last);
						mismatches++;
					end
					beats_checked++;
				end
			end
			if (in_valid && in_ready) begin
				predict_decode(in_byte, in_last);
			end
		end
		pending = expected_q.size();
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

	// lower-case 'a', used to build hex digits that must not decode
	localparam logic [7:0] LC_A = 8'h61;

	logic       clk       = 1'b0;
	logic       arst_n;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       out_last;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned beats_checked;

	// idle mix, in percent, for the sender and the receiver
	int unsigned send_gap_pct    = 0;
	int unsigned ready_stall_pct = 0;
	int unsigned beats_sent      = 0;
	int unsigned queries_sent    = 0;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	url_percent_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last)
	);

	query_decode_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.out_last      (out_last),
		.mismatches    (mismatches),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= ready_stall_pct);
	end

	// upper-case hex character for a nibble value
	function automatic logic [7:0] upper_hex(input int unsigned v);
		if (v < 10) begin
			return upd_pkg::CH_ZERO + 8'(v);
		end
		return upd_pkg::CH_UP_A + 8'(v - 10);
	endfunction

	// one input beat; entered and left at a falling edge
	task automatic push_beat(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic push_text(input string s, input logic end_last);
		for (int i = 0; i < s.len(); i++) begin
			push_beat(s[i], end_last && (i == s.len() - 1));
		end
	endtask

	// one random query string: escapes of several kinds, spaces and random bytes
	task automatic send_query();
		logic [7:0]  q[$];
		int unsigned want;
		int unsigned pick;
		want = $urandom_range(10, 1);
		while (q.size() < want) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				// escape with a sane first digit, decodes or falls through
				q.push_back(upd_pkg::CH_PCT);
				q.push_back(upd_pkg::CH_TWO + 8'($urandom_range(5)));
				q.push_back(upper_hex($urandom_range(15)));
			end else if (pick < 45) begin
				// escape with arbitrary digits, often dropped
				q.push_back(upd_pkg::CH_PCT);
				q.push_back(8'($urandom_range(255)));
				q.push_back(8'($urandom_range(255)));
			end else if (pick < 52) begin
				// lower-case hex letter never decodes
				q.push_back(upd_pkg::CH_PCT);
				q.push_back(upd_pkg::CH_TWO + 8'($urandom_range(5)));
				q.push_back(LC_A + 8'($urandom_range(5)));
			end else if (pick < 57) begin
				// second digit reopens an escape
				q.push_back(upd_pkg::CH_PCT);
				q.push_back(upd_pkg::CH_TWO + 8'($urandom_range(5)));
				q.push_back(upd_pkg::CH_PCT);
			end else if (pick < 67) begin
				q.push_back(upd_pkg::CH_SPACE);
			end else begin
				q.push_back(8'($urandom_range(255)));
			end
		end
		// sometimes cut the string in the middle of an escape
		if ($urandom_range(3) == 0) begin
			while (q.size() > want) begin
				void'(q.pop_back());
			end
		end
		foreach (q[i]) begin
			push_beat(q[i], i == q.size() - 1);
		end
		queries_sent++;
	endtask

	// hold the sender off until every predicted beat has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_phase(input int unsigned gap, input int unsigned stall,
		input int unsigned beats);
		int unsigned stop_at;
		send_gap_pct    = gap;
		ready_stall_pct = stall;
		stop_at         = beats_sent + beats;
		while (beats_sent < stop_at) begin
			send_query();
		end
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, each escape outcome, cut-short strings
		push_beat(8'h00, 1'b0);
		push_text(" ", 1'b0);       // raw space turns into plus
		push_text("%40", 1'b0);     // at sign
		push_text("%5C", 1'b0);     // backslash
		push_text("%7e", 1'b0);     // lower-case letter passes literally
		push_text("%1A", 1'b0);     // bad first digit drops the triple
		push_beat(8'hFF, 1'b0);     // byte right after a drop still decodes
		push_text("%4 ", 1'b0);     // undecodable code, trailing space
		push_text("%3%7E", 1'b1);   // second digit opens a new escape
		push_text("%", 1'b1);       // lone percent at the end
		push_text("%4", 1'b1);      // percent and digit at the end
		push_text("%88", 1'b1);     // nothing left, empty end marker
		queries_sent += 4;
		settle();

		// random: no idling, sender gaps, receiver stalls, then both
		run_phase(0, 0, 98);
		run_phase(50, 0, 98);
		run_phase(0, 50, 98);
		run_phase(13, 13, 98);

		// output register plus queue drain
		repeat (6) @(negedge clk);

		$display("covered %0d input beats in %0d query strings, %0d result beats checked",
			beats_sent, queries_sent, beats_checked);
		$display("idle mixes: none, sender 50%%, receiver 50%%, both 13%%");
		if (mismatches == 0 && pending == 0) begin
			$display("url_percent_decoder_unit regression: pass");
		end else begin
			$display("url_percent_decoder_unit regression: fail");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("url_percent_decoder_unit regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_unit.sv
rtl/upd_checker.sv
sim/query_decode_checker.sv
sim/testbench.sv
